@@ rtl/lpmd_pkg.sv @@
// shared types and constants for the length-prefixed message deframer
package lpmd_pkg;

   // header layout defaults
   localparam int ID_BYTES_DEF  = 2;
   localparam int LEN_BYTES_DEF = 2;

   // queue between front and back
   localparam int Q_DEPTH_DEF = 2;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int FIELD_W = 16;

   // size limit after reset
   localparam logic [FIELD_W-1:0] SIZE_LIMIT_RESET = 16'd2048;

   // result kind codes
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_BAD_ID  = 2'd2,
      KIND_BAD_LEN = 2'd3
   } kind_type;

   // one result word
   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data_byte;
      logic [FIELD_W-1:0]  msg_id;
      logic [FIELD_W-1:0]  msg_len;
      logic                first;
      logic                last;
   } rsp_item_type;

   // push side of the queue
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } q_push_type;

   // pop side status of the queue
   typedef struct packed {
      logic         full;
      logic         empty;
      rsp_item_type head;
   } q_status_type;

endpackage

@@ rtl/length_prefixed_message_deframer.sv @@
// Length-prefixed message deframer. Takes one byte word per cycle on req_, gathers a
// big-endian header of ID_BYTES id bytes and LEN_BYTES length bytes, checks both against
// the size limit register (written on csr_, unsigned compare, 2048 after reset) and then
// streams that many payload bytes on rsp_, each tagged with id, length, first (tuser[2])
// and last (tlast). A zero length gives one empty-message word; an id or length above the
// size limit gives one error word and all later input is consumed and dropped until reset.
// The front end handles every word combinationally, so req_ sustains one word per cycle
// while rsp_ is not stalled; a result is written into the small queue at the edge that
// takes its input word and then moves into the output register, which drives rsp_, once
// that register is empty or being taken. req_tready falls only when that queue is full.
module length_prefixed_message_deframer #(
   parameter int ID_BYTES  = lpmd_pkg::ID_BYTES_DEF,
   parameter int LEN_BYTES = lpmd_pkg::LEN_BYTES_DEF,
   parameter int Q_DEPTH   = lpmd_pkg::Q_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data_byte[7:0], msg_id[23:8], msg_len[39:24]
   output logic [2:0]  rsp_tuser,   // kind[1:0], first[2]
   output logic        rsp_tlast,
   // size limit write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);
   import lpmd_pkg::*;

   q_push_type   q_push;
   q_status_type q_status;
   logic         q_pop;

   lpmd_front #(
      .ID_BYTES  (ID_BYTES),
      .LEN_BYTES (LEN_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .q_full     (q_status.full),
      .q_push     (q_push)
   );

   lpmd_queue #(
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status)
   );

   lpmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/lpmd_front.sv @@
// front end: header collection, limit checks and payload tagging
module lpmd_front #(
   parameter int ID_BYTES  = lpmd_pkg::ID_BYTES_DEF,
   parameter int LEN_BYTES = lpmd_pkg::LEN_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // incoming byte stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   // size limit register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_wdata,
   // queue interface
   input  logic                 q_full,
   output lpmd_pkg::q_push_type q_push
);
   import lpmd_pkg::*;

   localparam int HDR_TOTAL = ID_BYTES + LEN_BYTES;
   localparam int HB_W      = (HDR_TOTAL - 1) * BYTE_W;
   localparam int CNT_W     = $clog2(HDR_TOTAL);
   localparam int ID_W      = ID_BYTES * BYTE_W;
   localparam int LEN_W     = LEN_BYTES * BYTE_W;
   localparam int CMP_W0    = (ID_W > LEN_W) ? ID_W : LEN_W;
   localparam int CMP_W     = (CMP_W0 > FIELD_W) ? CMP_W0 : FIELD_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HDR_TOTAL - 1);

   logic [FIELD_W-1:0] size_limit_ff, size_limit_in;
   logic [HB_W-1:0]    header_bytes_ff, header_bytes_in;
   logic [CNT_W-1:0]   header_count_ff, header_count_in;
   logic [FIELD_W-1:0] current_id_ff, current_id_in;
   logic [FIELD_W-1:0] current_len_ff, current_len_in;
   logic [FIELD_W-1:0] bytes_left_ff, bytes_left_in;
   logic               halted_ff, halted_in;

   logic                    accept;
   logic [HDR_TOTAL*8-1:0]  whole;
   logic [ID_W-1:0]         id_val;
   logic [LEN_W-1:0]        len_val;
   logic [CMP_W-1:0]        id_ext, len_ext, max_ext;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // split the completed header
   assign whole   = {header_bytes_ff, req_tdata};
   assign len_val = whole[LEN_W-1:0];
   assign id_val  = whole[HDR_TOTAL*8-1:LEN_W];
   assign id_ext  = CMP_W'(id_val);
   assign len_ext = CMP_W'(len_val);
   assign max_ext = CMP_W'(size_limit_ff);

   // classify the word and update state
   always_comb begin
      size_limit_in   = size_limit_ff;
      header_bytes_in = header_bytes_ff;
      header_count_in = header_count_ff;
      current_id_in   = current_id_ff;
      current_len_in  = current_len_ff;
      bytes_left_in   = bytes_left_ff;
      halted_in       = halted_ff;
      q_push          = '0;

      if (csr_valid && csr_ready) begin
         size_limit_in = csr_wdata;
      end

      if (accept && !halted_ff) begin
         if (bytes_left_ff != '0) begin
            // payload byte
            q_push.valid          = 1'b1;
            q_push.item.kind      = KIND_PAYLOAD;
            q_push.item.data_byte = req_tdata;
            q_push.item.msg_id    = current_id_ff;
            q_push.item.msg_len   = current_len_ff;
            q_push.item.first     = (bytes_left_ff == current_len_ff);
            q_push.item.last      = (bytes_left_ff == FIELD_W'(1));
            bytes_left_in         = bytes_left_ff - FIELD_W'(1);
         end else if (header_count_ff != CNT_LAST) begin
            // header byte, no result
            header_bytes_in = HB_W'({header_bytes_ff, req_tdata});
            header_count_in = header_count_ff + CNT_W'(1);
         end else begin
            // header complete
            header_bytes_in     = '0;
            header_count_in     = '0;
            q_push.item.msg_id  = FIELD_W'(id_val);
            q_push.item.msg_len = FIELD_W'(len_val);
            if (id_ext > max_ext) begin
               q_push.valid     = 1'b1;
               q_push.item.kind = KIND_BAD_ID;
               halted_in        = 1'b1;
            end else if (len_ext > max_ext) begin
               q_push.valid     = 1'b1;
               q_push.item.kind = KIND_BAD_LEN;
               halted_in        = 1'b1;
            end else begin
               current_id_in  = FIELD_W'(id_val);
               current_len_in = FIELD_W'(len_val);
               if (len_val == '0) begin
                  q_push.valid     = 1'b1;
                  q_push.item.kind = KIND_EMPTY;
                  q_push.item.last = 1'b1;
               end else begin
                  bytes_left_in = FIELD_W'(len_val);
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff   <= SIZE_LIMIT_RESET;
         header_bytes_ff <= '0;
         header_count_ff <= '0;
         current_id_ff   <= '0;
         current_len_ff  <= '0;
         bytes_left_ff   <= '0;
         halted_ff       <= 1'b0;
      end else begin
         size_limit_ff   <= size_limit_in;
         header_bytes_ff <= header_bytes_in;
         header_count_ff <= header_count_in;
         current_id_ff   <= current_id_in;
         current_len_ff  <= current_len_in;
         bytes_left_ff   <= bytes_left_in;
         halted_ff       <= halted_in;
      end
   end

endmodule

@@ rtl/lpmd_queue.sv @@
// short queue of result words between front and back
module lpmd_queue #(
   parameter int DEPTH = lpmd_pkg::Q_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpmd_pkg::q_push_type   q_push,
   input  logic                   q_pop,
   output lpmd_pkg::q_status_type q_status
);
   import lpmd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   rsp_item_type     slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_status.head  = slots_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_status.full;
   assign do_pop  = q_pop && !q_status.empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= q_push.item;
      end
   end

endmodule

@@ rtl/lpmd_back.sv @@
// back end: output register feeding the result stream
module lpmd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lpmd_pkg::q_status_type q_status,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,  // data_byte[7:0], msg_id[23:8], msg_len[39:24]
   output logic [2:0]             rsp_tuser,  // kind[1:0], first[2]
   output logic                   rsp_tlast
);
   import lpmd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;
   logic         load;

   // refill the register whenever it is empty or being taken
   assign load  = !valid_ff || rsp_tready;
   assign q_pop = load && !q_status.empty;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = !q_status.empty;
         item_in  = q_status.head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // pack the word
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {item_ff.msg_len, item_ff.msg_id, item_ff.data_byte};
   assign rsp_tuser  = {item_ff.first, item_ff.kind};
   assign rsp_tlast  = item_ff.last;

endmodule
